@@ hdl/vdi_pkg.sv @@
`default_nettype none

package vdi_pkg;

  // table geometry
  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = IDX_W + 1;

  // one cell per vertex component: pos x/y/z, tex u/v, normal x/y/z
  localparam int unsigned NUM_CELLS = 8;
  localparam int unsigned COMP_W    = 32;
  localparam int unsigned TEX_FIRST = 3;
  localparam int unsigned TEX_LAST  = 4;

  // words in flight along the chain: two stages per cell
  localparam int unsigned INFLIGHT_W = $clog2(2 * NUM_CELLS + 1);

  // configuration registers
  localparam int unsigned TOL_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_USE_TEX   = CFG_IDX_W'(1);
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(328);

  // stream widths
  localparam int unsigned IN_DATA_W  = NUM_CELLS * COMP_W;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 2;

  // probe handed from cell to cell: which entry, and whether it still matches
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             hit;
  } probe_t;

endpackage

`default_nettype wire

@@ hdl/vdi_cell.sv @@
`default_nettype none

module vdi_cell (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire vdi_pkg::probe_t                     probe_i,
  output      vdi_pkg::probe_t                     probe_o,
  input  wire logic                                query_load_i,
  input  wire logic signed [vdi_pkg::COMP_W-1:0]   query_i,
  input  wire logic                                cmp_en_i,
  input  wire logic        [vdi_pkg::TOL_W-1:0]    tol_i,
  input  wire logic                                wr_en_i,
  input  wire logic        [vdi_pkg::IDX_W-1:0]    wr_addr_i
);

  // this cell's component of every stored vertex
  logic signed [vdi_pkg::COMP_W-1:0] mem_q [vdi_pkg::MAX_VERTICES];
  logic signed [vdi_pkg::COMP_W-1:0] rd_q;
  logic signed [vdi_pkg::COMP_W-1:0] query_q;
  vdi_pkg::probe_t                   stage_q;
  vdi_pkg::probe_t                   probe_q;

  logic signed [vdi_pkg::COMP_W:0] diff;
  logic signed [vdi_pkg::COMP_W:0] tol_pos;
  logic signed [vdi_pkg::COMP_W:0] tol_neg;
  logic                            close;

  // component store: append writes the held query, probes read one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= query_q;
    end
    rd_q <= mem_q[probe_i.idx];
  end

  // query component held for the whole scan
  always_ff @(posedge clk_i) begin
    if (query_load_i) begin
      query_q <= query_i;
    end
  end

  // exact 33-bit difference, strictly inside the open tolerance window
  always_comb begin
    diff    = {query_q[vdi_pkg::COMP_W-1], query_q} - {rd_q[vdi_pkg::COMP_W-1], rd_q};
    tol_pos = $signed({{(vdi_pkg::COMP_W + 1 - vdi_pkg::TOL_W){1'b0}}, tol_i});
    tol_neg = -tol_pos;
    close   = (diff < tol_pos) && (diff > tol_neg);
  end

  // two stages: memory read, then compare and hand on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      probe_q <= '0;
    end else begin
      stage_q       <= probe_i;
      probe_q.valid <= stage_q.valid;
      probe_q.idx   <= stage_q.idx;
      probe_q.hit   <= stage_q.hit && (close || !cmp_en_i);
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

@@ hdl/vertex_dedup_indexer.sv @@
// every stored entry is probed once per vertex, the probe walking the stored entries one a cycle
// through the eight-cell chain; a new vertex is taken only after the last one's result is formed
// reset: asynchronous, active low; clears the entry count, the handshakes and the
// registers to tolerance 328 and texture compare on; the stores are not cleared
`default_nettype none

module vertex_dedup_indexer (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
  input  wire logic [vdi_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // new_shape
  input  wire logic                                 s_axis_tuser,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // vertex_index (10 bits), zero fill to 16 bits
  output      logic [vdi_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // was_added, table_full
  output      logic [vdi_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [vdi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [vdi_pkg::TOL_W-1:0]            cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  logic [vdi_pkg::TOL_W-1:0]      tol_q;
  logic                           use_tex_q;
  logic [vdi_pkg::CNT_W-1:0]      count_q, count_d;
  logic [vdi_pkg::CNT_W-1:0]      issue_q, issue_d;
  logic [vdi_pkg::INFLIGHT_W-1:0] inflight_q, inflight_d;
  logic                           hit_found_q, hit_found_d;
  logic [vdi_pkg::IDX_W-1:0]      hit_idx_q, hit_idx_d;

  logic [vdi_pkg::IDX_W-1:0] out_idx_q, out_idx_d;
  logic                      out_added_q, out_added_d;
  logic                      out_full_q, out_full_d;
  logic                      out_valid_q, out_valid_d;

  logic in_accept;
  logic issue;
  logic retire;
  logic finish;
  logic append;

  vdi_pkg::probe_t chain [vdi_pkg::NUM_CELLS+1];

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= vdi_pkg::TOL_RESET;
      use_tex_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vdi_pkg::REG_TOLERANCE: tol_q     <= cfg_data_i;
        vdi_pkg::REG_USE_TEX:   use_tex_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // probe injected at the head of the chain
  assign issue = (state_q == ST_SCAN) && (issue_q < count_q);
  always_comb begin
    chain[0].valid = issue;
    chain[0].idx   = issue_q[vdi_pkg::IDX_W-1:0];
    chain[0].hit   = 1'b1;
  end

  // one cell per component
  for (genvar g = 0; g < vdi_pkg::NUM_CELLS; g++) begin : g_cell
    logic cmp_en;
    assign cmp_en = ((g >= vdi_pkg::TEX_FIRST) && (g <= vdi_pkg::TEX_LAST)) ? use_tex_q : 1'b1;

    vdi_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .probe_i      (chain[g]),
      .probe_o      (chain[g+1]),
      .query_load_i (in_accept),
      .query_i      ($signed(s_axis_tdata[g*vdi_pkg::COMP_W +: vdi_pkg::COMP_W])),
      .cmp_en_i     (cmp_en),
      .tol_i        (tol_q),
      .wr_en_i      (append),
      .wr_addr_i    (count_q[vdi_pkg::IDX_W-1:0])
    );
  end

  assign retire = chain[vdi_pkg::NUM_CELLS].valid;
  assign finish = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);
  assign append = finish && !hit_found_q && (count_q < vdi_pkg::CNT_W'(vdi_pkg::MAX_VERTICES));

  // scan sequencer and result formation
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    hit_found_d = hit_found_q;
    hit_idx_d   = hit_idx_q;
    inflight_d  = inflight_q + vdi_pkg::INFLIGHT_W'(issue) - vdi_pkg::INFLIGHT_W'(retire);
    out_idx_d   = out_idx_q;
    out_added_d = out_added_q;
    out_full_d  = out_full_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    // first matching entry in index order wins
    if (retire && chain[vdi_pkg::NUM_CELLS].hit && !hit_found_q) begin
      hit_found_d = 1'b1;
      hit_idx_d   = chain[vdi_pkg::NUM_CELLS].idx;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser) begin
            count_d = '0;
          end
          issue_d     = '0;
          hit_found_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          issue_d = issue_q + vdi_pkg::CNT_W'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (inflight_q == '0) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (finish) begin
          out_valid_d = 1'b1;
          if (hit_found_q) begin
            out_idx_d   = hit_idx_q;
            out_added_d = 1'b0;
            out_full_d  = 1'b0;
          end else if (append) begin
            out_idx_d   = count_q[vdi_pkg::IDX_W-1:0];
            out_added_d = 1'b1;
            out_full_d  = 1'b0;
            count_d     = count_q + vdi_pkg::CNT_W'(1);
          end else begin
            out_idx_d   = '0;
            out_added_d = 1'b0;
            out_full_d  = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      inflight_q  <= '0;
      hit_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      inflight_q  <= inflight_d;
      hit_found_q <= hit_found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    out_idx_q   <= out_idx_d;
    out_added_q <= out_added_d;
    out_full_q  <= out_full_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(vdi_pkg::OUT_DATA_W - vdi_pkg::IDX_W){1'b0}}, out_idx_q};
  assign m_axis_tuser  = {out_full_q, out_added_q};

endmodule

`default_nettype wire

@@ hdl/vdi_checker.sv @@
`default_nettype none

module vdi_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [vdi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic [vdi_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // appended and full never reported together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("was_added and table_full both set");

  // a full report carries index zero and no fill bits are set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[vdi_pkg::OUT_DATA_W-1:vdi_pkg::IDX_W] == '0)
      && (!m_axis_tuser[1] || (m_axis_tdata == '0)))
    else $error("bad result index");

  // one vertex at a time: busy right after a vertex is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second vertex taken during scan");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (.*);

`default_nettype wire
